// ----- src/assert_macros.svh -----
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ----- src/pesc_pkg.sv -----
// shared types, constants and helpers for the expert slot cache
`timescale 1ns / 1ps
package pesc_pkg;

   localparam int LAYERS     = 64;
   localparam int MAX_SLOTS  = 16;
   localparam int LAYER_W    = (LAYERS > 1) ? $clog2(LAYERS) : 1;
   localparam int SLOT_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int TREE_STEPS = SLOT_W;
   localparam int STEP_W     = (TREE_STEPS > 1) ? $clog2(TREE_STEPS) : 1;

   localparam int LAYER_IN_W = 6;
   localparam int EXPERT_W   = 8;
   localparam int BYTES_W    = 32;
   localparam int COUNT_W    = 32;
   localparam int STAMP_W    = 40;
   localparam int SUM_W      = 42;
   localparam int LIMIT_W    = 5;
   localparam int CSR_IDX_W  = 8;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 120;

   localparam logic [CSR_IDX_W-1:0] REG_SLOTS_IN_USE   = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_REPLACE_POLICY = 8'd1;
   localparam logic                 POLICY_LRU         = 1'b0;
   localparam logic                 POLICY_LFU         = 1'b1;
   localparam logic [LIMIT_W-1:0]   LIMIT_RESET        = 5'd16;
   localparam logic                 POLICY_RESET       = 1'b1;

   typedef struct packed {
      logic                valid;
      logic [EXPERT_W-1:0] expert;
      logic [COUNT_W-1:0]  count;
      logic [STAMP_W-1:0]  stamp;
      logic [BYTES_W-1:0]  bytes;
   } slot_type;

   typedef slot_type [MAX_SLOTS-1:0] row_type;

   typedef struct packed {
      logic               valid;
      logic [SLOT_W-1:0]  idx;
      logic [COUNT_W-1:0] count;
      logic [STAMP_W-1:0] stamp;
   } cand_type;

   typedef struct packed {
      logic               clear;
      logic               capture;
      logic               read;
      logic               scan;
      logic               step;
      logic               write;
      logic [LAYER_W-1:0] clr_addr;
   } cmd_type;

   // true when a is a strictly better victim than b
   function automatic logic better(cand_type a, cand_type b, logic policy);
      logic r;
      if (policy == POLICY_LRU) begin
         r = a.stamp < b.stamp;
      end else begin
         r = (a.count < b.count) || ((a.count == b.count) && (a.stamp < b.stamp));
      end
      return r;
   endfunction

endpackage

// ----- src/per_layer_expert_slot_cache_core.sv -----
// top level of the per-layer expert slot cache
`timescale 1ns / 1ps
// usage:
// each request on the req_ stream names a layer, an expert and its span size;
// the block answers with exactly one response on the rsp_ stream: hit, the
// eviction if any, bytes to load and the total bytes now cached.
// every layer owns a row of slots held in one wide memory row; a request reads
// the row, finds a hit and the occupancy, runs a registered victim tree of
// log2(slots) levels and writes the row back.
// sequence: an accepted request passes through read, scan, 4 tree levels and
// write-back before its response is valid; one request is in flight at a
// time, so no new request is taken until the previous one has reached its
// write-back.
// reset: control clears at once, then a clearing pass writes zero into every
// layer row, one row a cycle, with req_tready low; csr writes are
// taken throughout.
// stall: the response sits in an output register; the next request is already
// taken and worked on, and only its write-back waits until the pending
// response has been taken.
// csr writes are accepted every cycle and must only occur while idle.
module per_layer_expert_slot_cache_core (
   input  logic                            clock,
   input  logic                            reset,
   // req_tdata: layer_index[5:0], expert_id[13:6], span_bytes[45:14], zero pad
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [pesc_pkg::REQ_DATA_W-1:0] req_tdata,
   // rsp_tdata: hit[0], evicted[1], victim_expert[9:2], victim_bytes[41:10],
   // load_bytes[73:42], cached_total_bytes[115:74], zero pad
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [pesc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // csr write channel: index 0 slots_in_use, index 1 replace_policy
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [pesc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pesc_pkg::LIMIT_W-1:0]    csr_data
);
   import pesc_pkg::*;
`include "assert_macros.svh"

   cmd_type cmd;

   // configuration is always taken
   assign csr_ready = 1'b1;

   pesc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   pesc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_tdata (rsp_tdata)
   );

   // a hit never loads or evicts
   `ASSERT_SAME(a_hit_no_load, clock, reset, rsp_tvalid && rsp_tdata[0], rsp_tdata[73:1] == '0)
   // no eviction means no victim reported
   `ASSERT_SAME(a_no_victim, clock, reset, rsp_tvalid && !rsp_tdata[1], rsp_tdata[41:2] == '0)
   // one request in flight: after acceptance the input closes
   `ASSERT_NEXT(a_one_inflight, clock, reset, req_tvalid && req_tready, !req_tready)
   // write-back and request acceptance never collide with the clearing pass
   `ASSERT_SAME(a_clear_excl, clock, reset, cmd.clear, !cmd.write && !req_tready)

endmodule

// ----- src/pesc_ctrl.sv -----
// sequencer for clearing, lookup, victim search and write-back
`timescale 1ns / 1ps
module pesc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output pesc_pkg::cmd_type cmd
);
   import pesc_pkg::*;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_SCAN  = 3'd3;
   localparam logic [2:0] S_TREE  = 3'd4;
   localparam logic [2:0] S_WRITE = 3'd5;

   logic [2:0]         state_ff, state_in;
   logic [LAYER_W-1:0] clr_ff, clr_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      step_in      = step_ff;
      cmd          = '0;
      cmd.clr_addr = clr_ff;
      req_tready   = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (clr_ff == LAYER_W'(LAYERS - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_READ;
            end
         end
         S_READ: begin
            cmd.read = 1'b1;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            step_in  = '0;
            state_in = S_TREE;
         end
         S_TREE: begin
            cmd.step = 1'b1;
            if (step_ff == STEP_W'(TREE_STEPS - 1)) begin
               state_in = S_WRITE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_WRITE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.write = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   assign rsp_valid_in = cmd.write ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   assign rsp_tvalid   = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- src/pesc_datapath.sv -----
// slot memory, lookup, victim tree, row update and result register
`timescale 1ns / 1ps
module pesc_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  pesc_pkg::cmd_type              cmd,
   input  logic [pesc_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           csr_valid,
   input  logic [pesc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pesc_pkg::LIMIT_W-1:0]    csr_data,
   output logic [pesc_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import pesc_pkg::*;

   row_type mem [LAYERS];

   logic [LIMIT_W-1:0]    lim_ff;
   logic                  policy_ff;
   logic [STAMP_W-1:0]    stamp_ff;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [LAYER_IN_W-1:0] layer_ff;
   logic [EXPERT_W-1:0]   expert_ff;
   logic [BYTES_W-1:0]    span_ff;
   row_type               row_ff;
   logic                  hit_ff, need_ff;
   logic [SLOT_W-1:0]     hit_idx_ff;
   cand_type              cand_ff [MAX_SLOTS];
   cand_type              cand_in [MAX_SLOTS];

   logic [LAYER_W-1:0]    addr;
   logic                  in_range;
   logic [MAX_SLOTS-1:0]  hit_vec, valid_vec, free_vec;
   logic                  hit_any;
   logic [SLOT_W-1:0]     hit_idx, free_idx, victim_idx;
   logic [7:0]            occ, lim_eff;
   logic                  do_evict;
   logic [STAMP_W-1:0]    stamp_nx;
   logic [BYTES_W-1:0]    vbytes, load;
   logic [EXPERT_W-1:0]   vexp;
   row_type               new_row;

   // result register
   logic                  o_hit_ff, o_evict_ff;
   logic [EXPERT_W-1:0]   o_vexp_ff;
   logic [BYTES_W-1:0]    o_vbytes_ff, o_load_ff;
   logic [SUM_W-1:0]      o_total_ff;

   assign addr     = layer_ff[LAYER_W-1:0];
   assign in_range = {3'b000, layer_ff} < 9'(LAYERS);
   assign stamp_nx = stamp_ff + 1'b1;

   // lookup over the row read from memory
   always_comb begin
      hit_any = 1'b0;
      hit_idx = '0;
      for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
         valid_vec[i] = row_ff[i].valid;
         hit_vec[i]   = row_ff[i].valid && (row_ff[i].expert == expert_ff);
         if (hit_vec[i]) begin
            hit_any = 1'b1;
            hit_idx = SLOT_W'(i);
         end
      end
      occ = 8'($countones(valid_vec));
      if (lim_ff == '0) begin
         lim_eff = 8'd1;
      end else if (8'(lim_ff) > 8'(MAX_SLOTS)) begin
         lim_eff = 8'(MAX_SLOTS);
      end else begin
         lim_eff = 8'(lim_ff);
      end
   end

   // victim tree: scan loads leaves, each step halves the field
   always_comb begin
      for (int i = 0; i < MAX_SLOTS; i++) begin
         cand_in[i] = cand_ff[i];
         if (cmd.scan) begin
            cand_in[i].valid = row_ff[i].valid;
            cand_in[i].idx   = SLOT_W'(i);
            cand_in[i].count = row_ff[i].count;
            cand_in[i].stamp = row_ff[i].stamp;
         end else if (cmd.step) begin
            if (2 * i + 1 < MAX_SLOTS) begin
               if (cand_ff[2*i+1].valid && (!cand_ff[2*i].valid ||
                   better(cand_ff[2*i+1], cand_ff[2*i], policy_ff))) begin
                  cand_in[i] = cand_ff[2*i+1];
               end else begin
                  cand_in[i] = cand_ff[2*i];
               end
            end else if (2 * i < MAX_SLOTS) begin
               cand_in[i] = cand_ff[2*i];
            end else begin
               cand_in[i] = '0;
            end
         end
      end
   end

   // row update at write-back
   always_comb begin
      victim_idx = cand_ff[0].idx;
      do_evict   = need_ff && cand_ff[0].valid;
      free_idx   = '0;
      for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
         free_vec[i] = !row_ff[i].valid || (do_evict && (victim_idx == SLOT_W'(i)));
         if (free_vec[i]) begin
            free_idx = SLOT_W'(i);
         end
      end
      vexp    = do_evict ? row_ff[victim_idx].expert : '0;
      vbytes  = do_evict ? row_ff[victim_idx].bytes : '0;
      load    = hit_ff ? '0 : span_ff;
      new_row = row_ff;
      if (hit_ff) begin
         if (~&row_ff[hit_idx_ff].count) begin
            new_row[hit_idx_ff].count = row_ff[hit_idx_ff].count + 1'b1;
         end
         new_row[hit_idx_ff].stamp = stamp_nx;
      end else begin
         if (do_evict) begin
            new_row[victim_idx] = '0;
         end
         new_row[free_idx].valid  = 1'b1;
         new_row[free_idx].expert = expert_ff;
         new_row[free_idx].count  = COUNT_W'(1);
         new_row[free_idx].stamp  = stamp_nx;
         new_row[free_idx].bytes  = span_ff;
      end
      sum_in = sum_ff - SUM_W'(vbytes) + SUM_W'(load);
   end

   // slot memory
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         mem[cmd.clr_addr] <= '0;
      end else if (cmd.write && in_range) begin
         mem[addr] <= new_row;
      end
      if (cmd.read) begin
         row_ff <= mem[addr];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         layer_ff  <= req_tdata[5:0];
         expert_ff <= req_tdata[13:6];
         span_ff   <= req_tdata[45:14];
      end
      if (cmd.scan) begin
         hit_ff     <= hit_any;
         hit_idx_ff <= hit_idx;
         need_ff    <= !hit_any && (occ >= lim_eff);
      end
      for (int i = 0; i < MAX_SLOTS; i++) begin
         cand_ff[i] <= cand_in[i];
      end
      if (cmd.write) begin
         o_hit_ff    <= in_range && hit_ff;
         o_evict_ff  <= in_range && do_evict;
         o_vexp_ff   <= in_range ? vexp : '0;
         o_vbytes_ff <= in_range ? vbytes : '0;
         o_load_ff   <= in_range ? load : '0;
         o_total_ff  <= in_range ? sum_in : sum_ff;
      end
   end

   // configuration and running state
   always_ff @(posedge clock) begin
      if (reset) begin
         lim_ff    <= LIMIT_RESET;
         policy_ff <= POLICY_RESET;
         stamp_ff  <= '0;
         sum_ff    <= '0;
      end else begin
         if (csr_valid && (csr_index == REG_SLOTS_IN_USE)) begin
            lim_ff <= csr_data;
         end
         if (csr_valid && (csr_index == REG_REPLACE_POLICY)) begin
            policy_ff <= csr_data[0];
         end
         if (cmd.write && in_range) begin
            stamp_ff <= stamp_nx;
            sum_ff   <= sum_in;
         end
      end
   end

   assign rsp_tdata = {4'b0000, o_total_ff, o_load_ff, o_vbytes_ff, o_vexp_ff,
                       o_evict_ff, o_hit_ff};

endmodule

// ----- dv/per_layer_expert_slot_cache_core_tb.sv -----
// testbench for the per-layer expert slot cache: directed table, random traffic, scoreboard
`timescale 1ns / 1ps
module per_layer_expert_slot_cache_core_tb;
   import pesc_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DIR_ROWS       = 24;
   localparam int RANDOM_ITEMS   = 1250;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [LIMIT_W-1:0]    csr_data;

   // one access to the cache
   typedef struct packed {
      logic [5:0]  layer;
      logic [7:0]  expert;
      logic [31:0] span;
   } access_type;

   // one outcome of an access
   typedef struct packed {
      logic        hit;
      logic        evicted;
      logic [7:0]  victim;
      logic [31:0] victim_bytes;
      logic [31:0] load_bytes;
      logic [41:0] total_bytes;
   } outcome_type;

   // directed row: access plus an optional typed-in outcome
   typedef struct {
      access_type  acc;
      logic        known;
      outcome_type out;
   } dir_row_type;

   // shadow of the cache state
   logic        sh_valid  [LAYERS][MAX_SLOTS];
   logic [7:0]  sh_expert [LAYERS][MAX_SLOTS];
   logic [31:0] sh_count  [LAYERS][MAX_SLOTS];
   logic [39:0] sh_stamp  [LAYERS][MAX_SLOTS];
   logic [31:0] sh_bytes  [LAYERS][MAX_SLOTS];
   logic [39:0] sh_now;
   logic [41:0] sh_total;
   logic [4:0]  sh_limit;
   logic        sh_policy;

   outcome_type pending_outcomes[$];
   int          mismatches;
   int          accepted_reqs;
   int          accepted_rsps;
   int          hits_seen;
   int          evictions_seen;
   int          idle_cycles;
   logic        hold_off;
   logic        no_idle;

   dir_row_type dir_rows[DIR_ROWS];

   per_layer_expert_slot_cache_core uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic logic [REQ_DATA_W-1:0] pack_access(access_type a);
      return {2'b00, a.span, a.expert, a.layer};
   endfunction

   function automatic outcome_type unpack_outcome(logic [RSP_DATA_W-1:0] d);
      outcome_type o;
      o.hit          = d[0];
      o.evicted      = d[1];
      o.victim       = d[9:2];
      o.victim_bytes = d[41:10];
      o.load_bytes   = d[73:42];
      o.total_bytes  = d[115:74];
      return o;
   endfunction

   task automatic clear_shadow();
      for (int l = 0; l < LAYERS; l++) begin
         for (int s = 0; s < MAX_SLOTS; s++) begin
            sh_valid[l][s]  = 1'b0;
            sh_expert[l][s] = '0;
            sh_count[l][s]  = '0;
            sh_stamp[l][s]  = '0;
            sh_bytes[l][s]  = '0;
         end
      end
      sh_now    = '0;
      sh_total  = '0;
      sh_limit  = LIMIT_RESET;
      sh_policy = POLICY_RESET;
   endtask

   // true when slot a is a strictly better victim than slot b
   function automatic logic beats(int l, int a, int b);
      if (sh_policy == POLICY_LRU) return sh_stamp[l][a] < sh_stamp[l][b];
      return (sh_count[l][a] < sh_count[l][b]) ||
             ((sh_count[l][a] == sh_count[l][b]) && (sh_stamp[l][a] < sh_stamp[l][b]));
   endfunction

   // predict the outcome of one access and update the shadow
   function automatic outcome_type predict_access(access_type a);
      outcome_type o;
      int          l;
      int          found;
      int          victim;
      int          occupied;
      int          limit;
      o = '0;
      l = a.layer;
      found = -1;
      victim = -1;
      occupied = 0;
      if (l < LAYERS) begin
         sh_now = sh_now + 40'd1;
         for (int s = 0; s < MAX_SLOTS; s++) begin
            if (sh_valid[l][s]) begin
               occupied++;
               if (found < 0 && sh_expert[l][s] == a.expert) found = s;
            end
         end
         if (found >= 0) begin
            if (sh_count[l][found] != 32'hFFFF_FFFF) sh_count[l][found]++;
            sh_stamp[l][found] = sh_now;
            o.hit = 1'b1;
         end else begin
            limit = (sh_limit < 1) ? 1 : (sh_limit > MAX_SLOTS ? MAX_SLOTS : sh_limit);
            if (occupied >= limit) begin
               for (int s = 0; s < MAX_SLOTS; s++)
                  if (sh_valid[l][s] && (victim < 0 || beats(l, s, victim))) victim = s;
               if (victim >= 0) begin
                  o.evicted      = 1'b1;
                  o.victim       = sh_expert[l][victim];
                  o.victim_bytes = sh_bytes[l][victim];
                  sh_total = sh_total - 42'(sh_bytes[l][victim]);
                  sh_valid[l][victim] = 1'b0;
               end
            end
            for (int s = 0; s < MAX_SLOTS; s++) begin
               if (!sh_valid[l][s]) begin
                  sh_valid[l][s]  = 1'b1;
                  sh_expert[l][s] = a.expert;
                  sh_count[l][s]  = 32'd1;
                  sh_stamp[l][s]  = sh_now;
                  sh_bytes[l][s]  = a.span;
                  sh_total = sh_total + 42'(a.span);
                  break;
               end
            end
            o.load_bytes = a.span;
         end
      end
      o.total_bytes = sh_total;
      return o;
   endfunction

   task automatic report_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch rsp %0d %s: expected %0h got %0h",
                     accepted_rsps, name, want, got);
      end
   endtask

   // reset stretch with all inputs idle; the clearing pass is covered by handshakes
   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = REG_SLOTS_IN_USE;
      csr_data = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   // response side: random stalls, a long hold-off and an idle-free stretch
   initial begin
      hold_off = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_tready <= 1'b0;
         end else if (no_idle) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= 9);
         end
      end
   end

   // scoreboard: compare each response with the oldest expectation
   always @(posedge clock) begin
      outcome_type got;
      outcome_type want;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = unpack_outcome(rsp_tdata);
            accepted_rsps++;
            if (pending_outcomes.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected rsp %0d", accepted_rsps);
            end else begin
               want = pending_outcomes.pop_front();
               report_field("hit", 64'(want.hit), 64'(got.hit));
               report_field("evicted", 64'(want.evicted), 64'(got.evicted));
               report_field("victim_expert", 64'(want.victim), 64'(got.victim));
               report_field("victim_bytes", 64'(want.victim_bytes), 64'(got.victim_bytes));
               report_field("load_bytes", 64'(want.load_bytes), 64'(got.load_bytes));
               report_field("cached_total_bytes", 64'(want.total_bytes),
                            64'(got.total_bytes));
               if (got.hit) hits_seen++;
               if (got.evicted) evictions_seen++;
            end
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress, %0d outstanding", pending_outcomes.size());
            $display("simulation failed");
            $finish;
         end
      end
   end

   // send one request, predicting on acceptance; typed-in outcome checked too
   task automatic send_access(access_type a, logic known, outcome_type typed);
      outcome_type o;
      @(negedge clock);
      while (!no_idle && $urandom_range(99) < 9) @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= pack_access(a);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      o = predict_access(a);
      if (known && o !== typed) begin
         mismatches++;
         if (mismatches <= 10) $display("typed outcome disagrees for layer %0d", a.layer);
      end
      pending_outcomes = {pending_outcomes, o};
      accepted_reqs++;
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   // write a register once the block is drained
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [4:0] value);
      wait (pending_outcomes.size() == 0);
      repeat (16) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == REG_SLOTS_IN_USE) sh_limit = value;
      else sh_policy = value[0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic access_type mk(int l, int e, logic [31:0] b);
      access_type a;
      a.layer = 6'(l);
      a.expert = 8'(e);
      a.span = b;
      return a;
   endfunction

   function automatic outcome_type oc(logic h, logic ev, int ve, logic [31:0] vb,
                                      logic [31:0] lb, logic [41:0] t);
      outcome_type o;
      o = {h, ev, 8'(ve), vb, lb, t};
      return o;
   endfunction

   task automatic fill_table();
      // first access after reset: plain miss, no eviction
      dir_rows[0] = '{mk(0, 0, 32'hFFFF_FFFF), 1'b1,
                      oc(0, 0, 0, 0, 32'hFFFF_FFFF, 42'hFFFF_FFFF)};
      // hit ignores span, load is zero
      dir_rows[1] = '{mk(0, 0, 32'd5), 1'b1, oc(1, 0, 0, 0, 0, 42'hFFFF_FFFF)};
      dir_rows[2] = '{mk(63, 255, 32'd0), 1'b1, oc(0, 0, 0, 0, 0, 42'hFFFF_FFFF)};
      dir_rows[3] = '{mk(63, 255, 32'd7), 1'b0, '0};
      for (int i = 4; i < 20; i++)
         dir_rows[i] = '{mk(5, i, 32'(i * 1000)), 1'b0, '0};
      dir_rows[20] = '{mk(5, 4, 32'd1), 1'b0, '0};
      dir_rows[21] = '{mk(5, 200, 32'hFFFF_FFFF), 1'b0, '0};
      dir_rows[22] = '{mk(5, 201, 32'hAAAA_5555), 1'b0, '0};
      dir_rows[23] = '{mk(1, 170, 32'h5555_AAAA), 1'b0, '0};
   endtask

   // random access: mostly a small expert pool on a few layers so hits and
   // evictions are common, with occasional wide values
   function automatic access_type rand_access();
      access_type a;
      a.layer  = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(3));
      a.expert = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(23));
      case ($urandom_range(3))
         0: a.span = $urandom;
         1: a.span = 32'hFFFF_FFFF - $urandom_range(3);
         default: a.span = $urandom_range(65535);
      endcase
      return a;
   endfunction

   // pressure phase: hold responses for a long stretch while requests are offered
   task automatic pressure_phase();
      fork
         begin
            hold_off = 1'b1;
            repeat (300) @(posedge clock);
            hold_off = 1'b0;
         end
         for (int i = 0; i < 12; i++) send_access(rand_access(), 1'b0, '0);
      join
   endtask

   initial begin
      logic [4:0] limits[6];
      mismatches = 0;
      accepted_reqs = 0;
      accepted_rsps = 0;
      hits_seen = 0;
      evictions_seen = 0;
      idle_cycles = 0;
      no_idle = 1'b0;
      limits = '{5'd0, 5'd1, 5'd3, 5'd31, 5'd16, 5'd2};
      clear_shadow();
      fill_table();
      wait (!reset);
      // limit of 4, recency policy for the directed walk
      write_csr(REG_SLOTS_IN_USE, 5'd4);
      write_csr(REG_REPLACE_POLICY, 5'(POLICY_LRU));
      for (int i = 0; i < DIR_ROWS; i++)
         send_access(dir_rows[i].acc, dir_rows[i].known, dir_rows[i].out);
      write_csr(REG_REPLACE_POLICY, 5'(POLICY_LFU));
      for (int i = 4; i < 10; i++) send_access(mk(7, i, 32'd1), 1'b0, '0);
      pressure_phase();
      // random phases over settings; one phase runs without idling
      for (int p = 0; p < 12; p++) begin
         write_csr(REG_SLOTS_IN_USE, limits[p % 6]);
         write_csr(REG_REPLACE_POLICY, (p < 6) ? 5'(POLICY_LRU) : 5'(POLICY_LFU));
         no_idle = (p == 4);
         for (int i = 0; i < RANDOM_ITEMS / 12; i++) send_access(rand_access(), 1'b0, '0);
      end
      no_idle = 1'b0;
      wait (pending_outcomes.size() == 0);
      repeat (20) @(posedge clock);
      $display("covered %0d requests, %0d hits, %0d evictions,",
               accepted_reqs, hits_seen, evictions_seen);
      $display("over limits 0..31 and both policies");
      if (mismatches == 0 && pending_outcomes.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d mismatches, %0d left over", mismatches, pending_outcomes.size());
         $display("simulation failed");
      end
      $finish;
   end

endmodule
